@@ design/stt_pkg.sv @@
// Package for the source text tokenizer: token record, lexer modes, kind codes
// and the character classification and keyword lookup functions.
// No dependencies; every other file of the block imports it.
package stt_pkg;

  localparam int unsigned KindW  = 6;
  localparam int unsigned OffW   = 16;
  localparam int unsigned LenW   = 16;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // Lexer modes, one-hot.
  typedef enum logic [9:0] {
    M_IDLE   = 10'b00_0000_0001,
    M_IDENT  = 10'b00_0000_0010,
    M_NUMBER = 10'b00_0000_0100,
    M_OP     = 10'b00_0000_1000,
    M_SLASH  = 10'b00_0001_0000,
    M_STRING = 10'b00_0010_0000,
    M_CHAR   = 10'b00_0100_0000,
    M_LINE   = 10'b00_1000_0000,
    M_BLOCK  = 10'b01_0000_0000,
    M_BSTAR  = 10'b10_0000_0000
  } lex_mode_e;

  // Token kind codes.
  localparam logic [KindW-1:0] K_IDENT    = 6'd0;
  localparam logic [KindW-1:0] K_NUMBER   = 6'd1;
  localparam logic [KindW-1:0] K_STRING   = 6'd2;
  localparam logic [KindW-1:0] K_CHAR     = 6'd3;
  localparam logic [KindW-1:0] K_IF       = 6'd4;
  localparam logic [KindW-1:0] K_ELSE     = 6'd5;
  localparam logic [KindW-1:0] K_RETURN   = 6'd6;
  localparam logic [KindW-1:0] K_FUNCTION = 6'd7;
  localparam logic [KindW-1:0] K_WHILE    = 6'd8;
  localparam logic [KindW-1:0] K_TYPE     = 6'd9;
  localparam logic [KindW-1:0] K_DEF      = 6'd10;
  localparam logic [KindW-1:0] K_STRUCT   = 6'd11;
  localparam logic [KindW-1:0] K_CONST    = 6'd12;
  localparam logic [KindW-1:0] K_PLUS     = 6'd13;
  localparam logic [KindW-1:0] K_MINUS    = 6'd14;
  localparam logic [KindW-1:0] K_STAR     = 6'd15;
  localparam logic [KindW-1:0] K_DIV      = 6'd16;
  localparam logic [KindW-1:0] K_ASSIGN   = 6'd17;
  localparam logic [KindW-1:0] K_EQ       = 6'd18;
  localparam logic [KindW-1:0] K_NE       = 6'd19;
  localparam logic [KindW-1:0] K_GT       = 6'd20;
  localparam logic [KindW-1:0] K_LT       = 6'd21;
  localparam logic [KindW-1:0] K_GE       = 6'd22;
  localparam logic [KindW-1:0] K_LE       = 6'd23;
  localparam logic [KindW-1:0] K_UNK_OP   = 6'd24;
  localparam logic [KindW-1:0] K_LBRACE   = 6'd25;
  localparam logic [KindW-1:0] K_RBRACE   = 6'd26;
  localparam logic [KindW-1:0] K_LPAREN   = 6'd27;
  localparam logic [KindW-1:0] K_RPAREN   = 6'd28;
  localparam logic [KindW-1:0] K_SEMI     = 6'd29;
  localparam logic [KindW-1:0] K_COMMA    = 6'd30;
  localparam logic [KindW-1:0] K_DOT      = 6'd31;
  localparam logic [KindW-1:0] K_END      = 6'd32;

  // Characters with a role of their own.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_BANG   = 8'h21;

  // Keywords packed little-endian, first character in the low byte.
  localparam logic [63:0] KW_IF       = 64'h0000_0000_0000_6669;
  localparam logic [63:0] KW_ELSE     = 64'h0000_0000_6573_6C65;
  localparam logic [63:0] KW_RETURN   = 64'h0000_6E72_7574_6572;
  localparam logic [63:0] KW_FUNCTION = 64'h6E6F_6974_636E_7566;
  localparam logic [63:0] KW_WHILE    = 64'h0000_0065_6C69_6877;
  localparam logic [63:0] KW_BYTE     = 64'h0000_0000_6574_7962;
  localparam logic [63:0] KW_INT      = 64'h0000_0000_0074_6E69;
  localparam logic [63:0] KW_FLOAT    = 64'h0000_0074_616F_6C66;
  localparam logic [63:0] KW_DEF      = 64'h0000_0000_0066_6564;
  localparam logic [63:0] KW_STRUCT   = 64'h0000_7463_7572_7473;
  localparam logic [63:0] KW_CONST    = 64'h0000_0074_736E_6F63;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [OffW-1:0]  offset;
    logic [LenW-1:0]  length;
    logic             last;
  } tok_t;

  // Up to two tokens written into the result queue per byte.
  typedef struct packed {
    logic v0;
    logic v1;
    tok_t r0;
    tok_t r1;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
           (c == CH_PCT) || (c == CH_EQ) || (c == CH_GT) || (c == CH_LT) ||
           (c == CH_BANG);
  endfunction

  // Returns zero for a byte that is not punctuation.
  function automatic logic [KindW-1:0] punct_kind(input logic [7:0] c);
    logic [KindW-1:0] k;
    case (c)
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h3B:   k = K_SEMI;
      8'h2C:   k = K_COMMA;
      8'h2E:   k = K_DOT;
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

  // The word buffer is zero above the stored length, so a length match plus
  // a full compare is an exact keyword match.
  function automatic logic [KindW-1:0] kw_kind(input logic [LenW-1:0] cnt,
                                               input logic [63:0] w);
    logic [KindW-1:0] k;
    k = K_IDENT;
    if      (cnt == 16'd2 && w == KW_IF)       k = K_IF;
    else if (cnt == 16'd4 && w == KW_ELSE)     k = K_ELSE;
    else if (cnt == 16'd6 && w == KW_RETURN)   k = K_RETURN;
    else if (cnt == 16'd8 && w == KW_FUNCTION) k = K_FUNCTION;
    else if (cnt == 16'd5 && w == KW_WHILE)    k = K_WHILE;
    else if (cnt == 16'd4 && w == KW_BYTE)     k = K_TYPE;
    else if (cnt == 16'd3 && w == KW_INT)      k = K_TYPE;
    else if (cnt == 16'd5 && w == KW_FLOAT)    k = K_TYPE;
    else if (cnt == 16'd3 && w == KW_DEF)      k = K_DEF;
    else if (cnt == 16'd6 && w == KW_STRUCT)   k = K_STRUCT;
    else if (cnt == 16'd5 && w == KW_CONST)    k = K_CONST;
    return k;
  endfunction

  function automatic logic [KindW-1:0] op_kind(input logic [LenW-1:0] cnt,
                                               input logic [15:0] ops);
    logic [KindW-1:0] k;
    logic [7:0]       a;
    logic [7:0]       b;
    a = ops[7:0];
    b = ops[15:8];
    k = K_UNK_OP;
    if (cnt == 16'd1) begin
      case (a)
        CH_PLUS:  k = K_PLUS;
        CH_MINUS: k = K_MINUS;
        CH_STAR:  k = K_STAR;
        CH_SLASH: k = K_DIV;
        CH_EQ:    k = K_ASSIGN;
        CH_GT:    k = K_GT;
        CH_LT:    k = K_LT;
        default:  k = K_UNK_OP;
      endcase
    end else if (cnt == 16'd2 && b == CH_EQ) begin
      case (a)
        CH_EQ:   k = K_EQ;
        CH_BANG: k = K_NE;
        CH_GT:   k = K_GE;
        CH_LT:   k = K_LE;
        default: k = K_UNK_OP;
      endcase
    end
    return k;
  endfunction

endpackage

@@ design/stt_intf.sv @@
// Channel interfaces of the source text tokenizer: the byte input channel and
// the token output channel, each with valid/ready. Depends on stt_pkg.
interface stt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface stt_token_if;
  import stt_pkg::*;
  logic             valid;
  logic             ready;
  logic [KindW-1:0] token_kind;
  logic [OffW-1:0]  token_offset;
  logic [LenW-1:0]  token_length;
  logic             last_of_run;

  modport source (output valid, output token_kind, output token_offset,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_offset,
                  input token_length, input last_of_run, output ready);
endinterface

@@ design/source_text_tokenizer.sv @@
// Top level of the source text tokenizer: lexer step plus result queue.
// Depends on stt_pkg, stt_intf (stt_byte_if, stt_token_if), stt_lexer, stt_out_queue.
//
// The tokenizer takes source text one byte per transfer on in_i, with byte 0
// ending the text, and gives one token per transfer on out_o. Spaces, line
// comments and block comments are skipped; identifiers (with keyword
// detection), decimal numbers, string and character literals, maximal runs of
// operator characters and punctuation come out with a kind code, the offset
// of their first byte (quotes excluded) and their length (saturating at
// 65535). An identifier, number or operator run is only known to be complete
// when the byte after it arrives, so its token is given together with the
// handling of that byte; one byte can thus cause two tokens, and
// last_of_run marks the final token caused by each byte. At the end of text
// any pending token is flushed, an unterminated literal is dropped, an end
// marker carrying the position of the 0 byte is given, and the offset count
// restarts at zero. Each byte is classified combinationally against the
// lexer state registers and its tokens are written into a four-entry result
// queue, whose head drives out_o. A byte is taken in every cycle while the
// queue has room for two tokens; the output side drains one token per cycle
// while out_o is ready, so the sustained rate is one byte per cycle for text
// that yields at most one token per byte, and the output port sets the pace
// when bytes yield two. OFFSET_BITS sets the width of the internal position
// counter; offsets wrap at 2^OFFSET_BITS and the low 16 bits are given.
module source_text_tokenizer #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input logic         clk_i,
  input logic         rst_ni,
  stt_byte_if.sink    in_i,
  stt_token_if.source out_o
);
  import stt_pkg::*;

  logic  room;
  logic  acc;
  push_t push;
  tok_t  head;

  // The byte input is ready whenever the queue can absorb two more tokens.
  assign in_i.ready = room;
  assign acc        = in_i.valid & room;

  stt_lexer #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .ch_i   (in_i.ch),
    .push_o (push)
  );

  stt_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (head)
  );

  // Token fields of the queue head go straight to the output channel.
  assign out_o.token_kind   = head.kind;
  assign out_o.token_offset = head.offset;
  assign out_o.token_length = head.length;
  assign out_o.last_of_run  = head.last;

endmodule

@@ design/stt_lexer.sv @@
// Lexer state registers and the combinational step that classifies one byte.
// Produces up to two tokens per accepted byte. Depends on stt_pkg.
module stt_lexer #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           acc_i,
  input  logic [7:0]     ch_i,
  output stt_pkg::push_t push_o
);
  import stt_pkg::*;

  localparam int unsigned ExtW = (OFFSET_BITS > OffW) ? OFFSET_BITS : OffW;

  lex_mode_e              mode_q, mode_d, new_mode;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] start_q, start_d, new_start;
  logic [LenW-1:0]        cnt_q, cnt_d, base_cnt;
  // The low two bytes of the word buffer double as the operator characters.
  logic [63:0]            buf_q, buf_d, base_buf;
  logic                   begin_tok, do_ext, start, is_end;
  logic                   fl_v, st_v;
  logic [KindW-1:0]       fl_kind, st_kind, pk;
  logic [LenW-1:0]        st_len;
  logic [ExtW-1:0]        pos_ext, start_ext;
  tok_t                   fl_tok, st_tok;

  assign pos_ext   = ExtW'(pos_q);
  assign start_ext = ExtW'(start_q);
  assign is_end    = (ch_i == CH_NUL);
  assign pk        = punct_kind(ch_i);

  always_comb begin
    mode_d    = mode_q;
    begin_tok = 1'b0;
    new_mode  = M_IDLE;
    new_start = pos_q;
    do_ext    = 1'b0;
    start     = 1'b0;
    fl_v      = 1'b0;
    fl_kind   = K_IDENT;
    st_v      = 1'b0;
    st_kind   = K_END;
    st_len    = '0;

    case (mode_q)
      M_IDENT: begin
        if (is_digit(ch_i) || is_letter(ch_i)) begin
          do_ext = 1'b1;
        end else begin
          fl_v    = 1'b1;
          fl_kind = kw_kind(cnt_q, buf_q);
          start   = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_digit(ch_i)) begin
          do_ext = 1'b1;
        end else begin
          fl_v    = 1'b1;
          fl_kind = K_NUMBER;
          start   = 1'b1;
        end
      end
      M_OP: begin
        if (is_op(ch_i)) begin
          do_ext = 1'b1;
        end else begin
          fl_v    = 1'b1;
          fl_kind = op_kind(cnt_q, buf_q[15:0]);
          start   = 1'b1;
        end
      end
      M_SLASH: begin
        if (ch_i == CH_SLASH) begin
          mode_d = M_LINE;
        end else if (ch_i == CH_STAR) begin
          mode_d = M_BLOCK;
        end else if (is_op(ch_i)) begin
          mode_d = M_OP;
          do_ext = 1'b1;
        end else begin
          fl_v    = 1'b1;
          fl_kind = op_kind(cnt_q, buf_q[15:0]);
          start   = 1'b1;
        end
      end
      M_STRING: begin
        if (is_end) begin
          start = 1'b1;
        end else if (ch_i == CH_DQUOTE) begin
          fl_v    = 1'b1;
          fl_kind = K_STRING;
          mode_d  = M_IDLE;
        end else begin
          do_ext = 1'b1;
        end
      end
      M_CHAR: begin
        if (is_end) begin
          start = 1'b1;
        end else if (ch_i == CH_SQUOTE) begin
          fl_v    = 1'b1;
          fl_kind = K_CHAR;
          mode_d  = M_IDLE;
        end else begin
          do_ext = 1'b1;
        end
      end
      M_LINE: begin
        if (is_end) begin
          start = 1'b1;
        end else if (ch_i == CH_LF) begin
          mode_d = M_IDLE;
        end
      end
      M_BLOCK: begin
        if (is_end) begin
          start = 1'b1;
        end else begin
          mode_d = (ch_i == CH_STAR) ? M_BSTAR : M_BLOCK;
        end
      end
      M_BSTAR: begin
        if (is_end) begin
          start = 1'b1;
        end else if (ch_i == CH_SLASH) begin
          mode_d = M_IDLE;
        end else begin
          mode_d = (ch_i == CH_STAR) ? M_BSTAR : M_BLOCK;
        end
      end
      default: begin
        start = 1'b1;
      end
    endcase

    // The byte that ended a token, or any byte between tokens, may open one.
    if (start) begin
      mode_d = M_IDLE;
      if (is_end) begin
        st_v    = 1'b1;
        st_kind = K_END;
        st_len  = '0;
      end else if (ch_i == CH_SLASH) begin
        begin_tok = 1'b1;
        new_mode  = M_SLASH;
        do_ext    = 1'b1;
      end else if (is_op(ch_i)) begin
        begin_tok = 1'b1;
        new_mode  = M_OP;
        do_ext    = 1'b1;
      end else if (is_digit(ch_i)) begin
        begin_tok = 1'b1;
        new_mode  = M_NUMBER;
        do_ext    = 1'b1;
      end else if (is_letter(ch_i)) begin
        begin_tok = 1'b1;
        new_mode  = M_IDENT;
        do_ext    = 1'b1;
      end else if (ch_i == CH_DQUOTE) begin
        begin_tok = 1'b1;
        new_mode  = M_STRING;
        new_start = pos_q + 1'b1;
      end else if (ch_i == CH_SQUOTE) begin
        begin_tok = 1'b1;
        new_mode  = M_CHAR;
        new_start = pos_q + 1'b1;
      end else if (pk != K_IDENT) begin
        st_v    = 1'b1;
        st_kind = pk;
        st_len  = LenW'(1);
      end
    end

    base_cnt = begin_tok ? '0 : cnt_q;
    base_buf = begin_tok ? '0 : buf_q;
    start_d  = begin_tok ? new_start : start_q;
    if (begin_tok) begin
      mode_d = new_mode;
    end

    // Append the byte: only the first eight are kept, the count saturates.
    buf_d = base_buf;
    cnt_d = base_cnt;
    if (do_ext) begin
      for (int i = 0; i < 8; i++) begin
        if (base_cnt[LenW-1:3] == '0 && base_cnt[2:0] == 3'(i)) begin
          buf_d[8*i +: 8] = ch_i;
        end
      end
      if (base_cnt != {LenW{1'b1}}) begin
        cnt_d = base_cnt + 1'b1;
      end
    end

    pos_d = pos_q + 1'b1;

    // End of text returns everything to the reset state.
    if (start && is_end) begin
      mode_d  = M_IDLE;
      pos_d   = '0;
      start_d = '0;
      cnt_d   = '0;
      buf_d   = '0;
    end
  end

  always_comb begin
    fl_tok.kind   = fl_kind;
    fl_tok.offset = start_ext[OffW-1:0];
    fl_tok.length = cnt_q;
    fl_tok.last   = ~st_v;
    st_tok.kind   = st_kind;
    st_tok.offset = pos_ext[OffW-1:0];
    st_tok.length = st_len;
    st_tok.last   = 1'b1;

    push_o.v0 = acc_i & (fl_v | st_v);
    push_o.v1 = acc_i & fl_v & st_v;
    push_o.r0 = fl_v ? fl_tok : st_tok;
    push_o.r1 = st_tok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      cnt_q   <= '0;
      buf_q   <= '0;
    end else if (acc_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      cnt_q   <= cnt_d;
      buf_q   <= buf_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.v1 |-> push_o.v0)
    else $error("second token pushed without a first");

  a_end_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && ch_i == CH_NUL) |->
      (push_o.v1 ? (push_o.r1.kind == K_END)
                 : (push_o.v0 && push_o.r0.kind == K_END && push_o.r0.last)))
    else $error("end of text did not end with an end marker");

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && ch_i == CH_NUL) |=> (pos_q == '0 && mode_q == M_IDLE && cnt_q == '0))
    else $error("lexer state not cleared after end of text");
`endif

endmodule

@@ design/stt_out_queue.sv @@
// Four-entry result queue: takes up to two tokens per cycle from the lexer and
// hands one token per transfer to the output channel. Depends on stt_pkg.
module stt_out_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  stt_pkg::push_t push_i,
  output logic           room_o,
  output logic           valid_o,
  input  logic           ready_i,
  output stt_pkg::tok_t  data_o
);
  import stt_pkg::*;

  tok_t             mem_q [QDepth];
  logic [QPtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             pop;
  logic [QPtrW-1:0] wp_next;

  assign room_o  = (cnt_q <= QCntW'(QDepth - 2));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];
  assign pop     = valid_o & ready_i;
  assign wp_next = wp_q + 1'b1;

  always_comb begin
    wp_d  = wp_q + QPtrW'(push_i.v0) + QPtrW'(push_i.v1);
    rp_d  = rp_q + QPtrW'(pop);
    cnt_d = cnt_q + QCntW'(push_i.v0) + QCntW'(push_i.v1) - QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wp_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_q[wp_next] <= push_i.r1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.v0 |-> room_o)
    else $error("tokens pushed while the queue lacks room for two");
`endif

endmodule
